@@ sv/c8ie_pkg.sv @@
// shared types and constants for the chip8 instruction execute block
// decoded op format, fault codes, opcode class codes and defaults
// no dependencies
package c8ie_pkg;

	localparam int STACK_DEPTH_DEF  = 16;
	localparam int ADDRESS_BITS_DEF = 12;

	localparam int PC_OUT_W    = 12;
	localparam int LEVEL_OUT_W = 5;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [11:0] START_RESET = 12'h200;

	// register index taken from paddr[2]
	localparam logic REG_START_ADDRESS = 1'b0;

	// opcode classes (top nibble)
	localparam logic [3:0] CLS_SYS     = 4'h0;
	localparam logic [3:0] CLS_JP      = 4'h1;
	localparam logic [3:0] CLS_CALL    = 4'h2;
	localparam logic [3:0] CLS_SE      = 4'h3;
	localparam logic [3:0] CLS_SNE     = 4'h4;
	localparam logic [3:0] CLS_SE_REG  = 4'h5;
	localparam logic [3:0] CLS_LD      = 4'h6;
	localparam logic [3:0] CLS_ADD     = 4'h7;
	localparam logic [3:0] CLS_ALU     = 4'h8;
	localparam logic [3:0] CLS_SNE_REG = 4'h9;
	localparam logic [3:0] CLS_LD_I    = 4'hA;
	localparam logic [3:0] CLS_JP_V0   = 4'hB;
	localparam logic [3:0] CLS_RND     = 4'hC;
	localparam logic [3:0] CLS_MISC    = 4'hF;

	localparam logic [15:0] INS_RET = 16'h00EE;

	// low byte of the FXnn group
	localparam logic [7:0] FX_LD_VX_DT = 8'h07;
	localparam logic [7:0] FX_LD_DT    = 8'h15;
	localparam logic [7:0] FX_LD_ST    = 8'h18;
	localparam logic [7:0] FX_ADD_I    = 8'h1E;

	localparam logic [3:0] SUB_NONE = 4'h0;
	localparam logic [3:0] V0_IDX   = 4'h0;
	localparam logic [3:0] VF_IDX   = 4'hF;

	typedef enum logic [4:0] {
		K_BAD,
		K_RET,
		K_JP,
		K_CALL,
		K_SE_IMM,
		K_SNE_IMM,
		K_SE_REG,
		K_SNE_REG,
		K_LD_IMM,
		K_ADD_IMM,
		K_ALU,
		K_LD_I,
		K_JP_V0,
		K_LD_VX_DT,
		K_LD_DT,
		K_LD_ST,
		K_ADD_I
	} kind_t;

	typedef enum logic [3:0] {
		ALU_MOV  = 4'h0,
		ALU_OR   = 4'h1,
		ALU_AND  = 4'h2,
		ALU_XOR  = 4'h3,
		ALU_ADD  = 4'h4,
		ALU_SUB  = 4'h5,
		ALU_SHR  = 4'h6,
		ALU_SUBN = 4'h7,
		ALU_SHL  = 4'hE
	} alu_t;

	typedef enum logic [1:0] {
		FAULT_NONE        = 2'd0,
		FAULT_UNSUPPORTED = 2'd1,
		FAULT_OVERFLOW    = 2'd2,
		FAULT_UNDERFLOW   = 2'd3
	} fault_t;

	typedef struct packed {
		kind_t       kind;
		alu_t        alu;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [7:0]  imm;
		logic [11:0] nnn;
	} op_t;

	typedef struct packed {
		logic        load;
		logic [11:0] start;
	} cfg_t;

endpackage

@@ sv/c8ie_ifs.sv @@
// valid/ready channel interfaces for instruction beats and result beats
// depends on c8ie_pkg for the output field widths
interface c8ie_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] instruction;
	logic [7:0]  random_byte;

	modport source (output valid, output instruction, output random_byte, input ready);
	modport sink (input valid, input instruction, input random_byte, output ready);
endinterface

interface c8ie_out_if;
	logic                                valid;
	logic                                ready;
	logic [c8ie_pkg::PC_OUT_W-1:0]       next_pc;
	logic [15:0]                         index_value;
	logic [3:0]                          dest_index;
	logic [7:0]                          dest_value;
	logic                                dest_written;
	logic [7:0]                          flag_register;
	logic [c8ie_pkg::LEVEL_OUT_W-1:0]    stack_level;
	logic [1:0]                          fault;

	modport source (
		output valid, output next_pc, output index_value, output dest_index,
		output dest_value, output dest_written, output flag_register,
		output stack_level, output fault, input ready
	);
	modport sink (
		input valid, input next_pc, input index_value, input dest_index,
		input dest_value, input dest_written, input flag_register,
		input stack_level, input fault, output ready
	);
endinterface

@@ sv/c8ie_front.sv @@
// front end: accepts instruction beats and decodes them into op_t
// depends on c8ie_pkg and c8ie_in_if
module c8ie_front (
	c8ie_in_if.sink         instr,
	output logic            push,
	output c8ie_pkg::op_t   push_op,
	input  logic            push_ready
);

	logic [15:0] ins;
	logic [3:0]  cls;
	logic [3:0]  sub;

	assign ins = instr.instruction;
	assign cls = ins[15:12];
	assign sub = ins[3:0];

	assign instr.ready = push_ready;
	assign push        = instr.valid;

	always_comb begin
		push_op.kind = c8ie_pkg::K_BAD;
		push_op.alu  = c8ie_pkg::alu_t'(sub);
		push_op.x    = ins[11:8];
		push_op.y    = ins[7:4];
		push_op.imm  = ins[7:0];
		push_op.nnn  = ins[11:0];
		case (cls)
			c8ie_pkg::CLS_SYS: begin
				if (ins == c8ie_pkg::INS_RET) push_op.kind = c8ie_pkg::K_RET;
			end
			c8ie_pkg::CLS_JP:   push_op.kind = c8ie_pkg::K_JP;
			c8ie_pkg::CLS_CALL: push_op.kind = c8ie_pkg::K_CALL;
			c8ie_pkg::CLS_SE:   push_op.kind = c8ie_pkg::K_SE_IMM;
			c8ie_pkg::CLS_SNE:  push_op.kind = c8ie_pkg::K_SNE_IMM;
			c8ie_pkg::CLS_SE_REG: begin
				if (sub == c8ie_pkg::SUB_NONE) push_op.kind = c8ie_pkg::K_SE_REG;
			end
			c8ie_pkg::CLS_SNE_REG: begin
				if (sub == c8ie_pkg::SUB_NONE) push_op.kind = c8ie_pkg::K_SNE_REG;
			end
			c8ie_pkg::CLS_LD:   push_op.kind = c8ie_pkg::K_LD_IMM;
			c8ie_pkg::CLS_ADD:  push_op.kind = c8ie_pkg::K_ADD_IMM;
			c8ie_pkg::CLS_ALU: begin
				case (c8ie_pkg::alu_t'(sub))
					c8ie_pkg::ALU_MOV, c8ie_pkg::ALU_OR, c8ie_pkg::ALU_AND,
					c8ie_pkg::ALU_XOR, c8ie_pkg::ALU_ADD, c8ie_pkg::ALU_SUB,
					c8ie_pkg::ALU_SHR, c8ie_pkg::ALU_SUBN,
					c8ie_pkg::ALU_SHL: push_op.kind = c8ie_pkg::K_ALU;
					default:           push_op.kind = c8ie_pkg::K_BAD;
				endcase
			end
			c8ie_pkg::CLS_LD_I:  push_op.kind = c8ie_pkg::K_LD_I;
			c8ie_pkg::CLS_JP_V0: push_op.kind = c8ie_pkg::K_JP_V0;
			// random mask folds into an immediate load
			c8ie_pkg::CLS_RND: begin
				push_op.kind = c8ie_pkg::K_LD_IMM;
				push_op.imm  = ins[7:0] & instr.random_byte;
			end
			c8ie_pkg::CLS_MISC: begin
				case (ins[7:0])
					c8ie_pkg::FX_LD_VX_DT: push_op.kind = c8ie_pkg::K_LD_VX_DT;
					c8ie_pkg::FX_LD_DT:    push_op.kind = c8ie_pkg::K_LD_DT;
					c8ie_pkg::FX_LD_ST:    push_op.kind = c8ie_pkg::K_LD_ST;
					c8ie_pkg::FX_ADD_I:    push_op.kind = c8ie_pkg::K_ADD_I;
					default:               push_op.kind = c8ie_pkg::K_BAD;
				endcase
			end
			default: push_op.kind = c8ie_pkg::K_BAD;
		endcase
	end

endmodule

@@ sv/c8ie_fifo.sv @@
// two-entry queue of decoded ops between front and back
// depends on c8ie_pkg
module c8ie_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  c8ie_pkg::op_t push_op,
	output logic          push_ready,
	output logic          head_valid,
	output c8ie_pkg::op_t head_op,
	input  logic          pop
);

	c8ie_pkg::op_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_op    = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({do_push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/c8ie_back.sv @@
// back end: register read stage, combinational execute and result register
// holds pc, index, v0..vf, return stack and timers; depends on c8ie_pkg and c8ie_out_if
module c8ie_back #(
	parameter int STACK_DEPTH  = c8ie_pkg::STACK_DEPTH_DEF,
	parameter int ADDRESS_BITS = c8ie_pkg::ADDRESS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  c8ie_pkg::cfg_t    cfg,
	input  logic              head_valid,
	input  c8ie_pkg::op_t     head_op,
	output logic              pop,
	c8ie_out_if.source        result
);

	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int STK_ENTRIES = 2 ** IDX_W;
	localparam int JW          = ADDRESS_BITS + 1;

	// read stage
	logic          s2_valid_q;
	c8ie_pkg::op_t op_s2;
	logic [7:0]    rdx_mem_s2;
	logic [7:0]    rdy_mem_s2;
	logic          rdx_ok_s2;
	logic          rdy_ok_s2;
	logic          fwd_hit_q;
	logic [3:0]    fwd_idx_q;
	logic [7:0]    fwd_val_q;

	// architectural state
	logic [7:0]              gpr_mem [16];
	logic [15:0]             gpr_valid_q;
	logic [7:0]              v0_q;
	logic [7:0]              vf_q;
	logic [ADDRESS_BITS-1:0] pc_q;
	logic [15:0]             idx_q;
	logic [7:0]              dt_q;
	logic [7:0]              st_q;
	logic [SP_W-1:0]         sp_q;
	logic [ADDRESS_BITS-1:0] stk_mem [STK_ENTRIES];
	logic [ADDRESS_BITS-1:0] tos_q;
	logic [ADDRESS_BITS-1:0] below_q;

	// result register
	logic                              out_valid_q;
	logic [c8ie_pkg::PC_OUT_W-1:0]     next_pc_q;
	logic [15:0]                       index_value_q;
	logic [3:0]                        dest_index_q;
	logic [7:0]                        dest_value_q;
	logic                              dest_written_q;
	logic [7:0]                        flag_register_q;
	logic [c8ie_pkg::LEVEL_OUT_W-1:0]  stack_level_q;
	c8ie_pkg::fault_t                  fault_q;

	// execute
	logic                    exec_go;
	logic [7:0]              vx;
	logic [7:0]              vy;
	logic [ADDRESS_BITS-1:0] pc_inc;
	logic [ADDRESS_BITS-1:0] pc_skip;
	logic [ADDRESS_BITS-1:0] pc_n;
	logic [15:0]             idx_n;
	logic [7:0]              dt_n;
	logic [7:0]              st_n;
	logic [SP_W-1:0]         sp_n;
	logic [SP_W-1:0]         sp_next;
	logic [SP_W-1:0]         below_ptr;
	logic                    wr;
	logic                    has_flag;
	logic                    push_stk;
	logic                    pop_stk;
	logic [7:0]              res;
	logic [7:0]              flag;
	logic [7:0]              vf_n;
	logic [8:0]              sum9;
	logic [JW-1:0]           jsum;
	c8ie_pkg::fault_t        fault_n;

	assign exec_go = s2_valid_q && (!out_valid_q || result.ready);
	assign pop     = head_valid && (!s2_valid_q || exec_go);

	always_comb begin
		if (op_s2.x == c8ie_pkg::VF_IDX) vx = vf_q;
		else if (fwd_hit_q && fwd_idx_q == op_s2.x) vx = fwd_val_q;
		else vx = rdx_ok_s2 ? rdx_mem_s2 : 8'h00;
		if (op_s2.y == c8ie_pkg::VF_IDX) vy = vf_q;
		else if (fwd_hit_q && fwd_idx_q == op_s2.y) vy = fwd_val_q;
		else vy = rdy_ok_s2 ? rdy_mem_s2 : 8'h00;
	end

	assign pc_inc  = pc_q + ADDRESS_BITS'(2);
	assign pc_skip = pc_q + ADDRESS_BITS'(4);
	assign sum9    = {1'b0, vx} + {1'b0, vy};
	assign jsum    = JW'(op_s2.nnn) + JW'(v0_q);

	always_comb begin
		pc_n     = pc_inc;
		idx_n    = idx_q;
		dt_n     = dt_q;
		st_n     = st_q;
		sp_n     = sp_q;
		wr       = 1'b0;
		has_flag = 1'b0;
		push_stk = 1'b0;
		pop_stk  = 1'b0;
		res      = 8'h00;
		flag     = 8'h00;
		fault_n  = c8ie_pkg::FAULT_NONE;
		case (op_s2.kind)
			c8ie_pkg::K_RET: begin
				if (sp_q == '0) begin
					fault_n = c8ie_pkg::FAULT_UNDERFLOW;
				end else begin
					sp_n    = sp_q - SP_W'(1);
					pc_n    = tos_q;
					pop_stk = 1'b1;
				end
			end
			c8ie_pkg::K_JP: pc_n = ADDRESS_BITS'(op_s2.nnn);
			c8ie_pkg::K_CALL: begin
				if (sp_q >= SP_W'(STACK_DEPTH)) begin
					fault_n = c8ie_pkg::FAULT_OVERFLOW;
				end else begin
					sp_n     = sp_q + SP_W'(1);
					pc_n     = ADDRESS_BITS'(op_s2.nnn);
					push_stk = 1'b1;
				end
			end
			c8ie_pkg::K_SE_IMM:  if (vx == op_s2.imm) pc_n = pc_skip;
			c8ie_pkg::K_SNE_IMM: if (vx != op_s2.imm) pc_n = pc_skip;
			c8ie_pkg::K_SE_REG:  if (vx == vy) pc_n = pc_skip;
			c8ie_pkg::K_SNE_REG: if (vx != vy) pc_n = pc_skip;
			c8ie_pkg::K_LD_IMM: begin
				wr  = 1'b1;
				res = op_s2.imm;
			end
			c8ie_pkg::K_ADD_IMM: begin
				wr  = 1'b1;
				res = vx + op_s2.imm;
			end
			c8ie_pkg::K_ALU: begin
				wr = 1'b1;
				case (op_s2.alu)
					c8ie_pkg::ALU_MOV: res = vy;
					c8ie_pkg::ALU_OR:  res = vx | vy;
					c8ie_pkg::ALU_AND: res = vx & vy;
					c8ie_pkg::ALU_XOR: res = vx ^ vy;
					c8ie_pkg::ALU_ADD: begin
						res      = sum9[7:0];
						has_flag = 1'b1;
						flag     = {7'd0, sum9[8]};
					end
					c8ie_pkg::ALU_SUB: begin
						res      = vx - vy;
						has_flag = 1'b1;
						flag     = {7'd0, vx > vy};
					end
					c8ie_pkg::ALU_SHR: begin
						res      = {1'b0, vx[7:1]};
						has_flag = 1'b1;
						flag     = {7'd0, vx[0]};
					end
					c8ie_pkg::ALU_SUBN: begin
						res      = vy - vx;
						has_flag = 1'b1;
						flag     = {7'd0, vy > vx};
					end
					c8ie_pkg::ALU_SHL: begin
						res      = {vx[6:0], 1'b0};
						has_flag = 1'b1;
						flag     = {7'd0, vx[7]};
					end
					default: begin
						wr      = 1'b0;
						fault_n = c8ie_pkg::FAULT_UNSUPPORTED;
					end
				endcase
			end
			c8ie_pkg::K_LD_I:  idx_n = {4'h0, op_s2.nnn};
			c8ie_pkg::K_JP_V0: pc_n = jsum[ADDRESS_BITS-1:0];
			c8ie_pkg::K_LD_VX_DT: begin
				wr  = 1'b1;
				res = dt_q;
			end
			c8ie_pkg::K_LD_DT: dt_n = vx;
			c8ie_pkg::K_LD_ST: st_n = vx;
			c8ie_pkg::K_ADD_I: idx_n = idx_q + {8'h00, vx};
			default: fault_n = c8ie_pkg::FAULT_UNSUPPORTED;
		endcase
	end

	// flag write lands after the destination write
	always_comb begin
		if (has_flag) vf_n = flag;
		else if (wr && op_s2.x == c8ie_pkg::VF_IDX) vf_n = res;
		else vf_n = vf_q;
	end

	// below_q always tracks the entry under the top of stack
	assign sp_next   = exec_go ? sp_n : sp_q;
	assign below_ptr = sp_next - SP_W'(2);

	always_ff @(posedge clk) begin
		if (exec_go && push_stk) stk_mem[sp_q[IDX_W-1:0]] <= pc_inc;
		below_q <= stk_mem[below_ptr[IDX_W-1:0]];
		if (exec_go && push_stk) tos_q <= pc_inc;
		else if (exec_go && pop_stk) tos_q <= below_q;
	end

	always_ff @(posedge clk) begin
		if (exec_go && wr) gpr_mem[op_s2.x] <= res;
		if (pop) begin
			rdx_mem_s2 <= gpr_mem[head_op.x];
			rdy_mem_s2 <= gpr_mem[head_op.y];
			op_s2      <= head_op;
			fwd_idx_q  <= op_s2.x;
			fwd_val_q  <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			rdx_ok_s2   <= 1'b0;
			rdy_ok_s2   <= 1'b0;
			fwd_hit_q   <= 1'b0;
			gpr_valid_q <= '0;
			v0_q        <= 8'h00;
			vf_q        <= 8'h00;
			pc_q        <= ADDRESS_BITS'(c8ie_pkg::START_RESET);
			idx_q       <= 16'h0000;
			dt_q        <= 8'h00;
			st_q        <= 8'h00;
			sp_q        <= '0;
		end else begin
			if (pop) begin
				s2_valid_q <= 1'b1;
				rdx_ok_s2  <= gpr_valid_q[head_op.x];
				rdy_ok_s2  <= gpr_valid_q[head_op.y];
				fwd_hit_q  <= exec_go && wr;
			end else if (exec_go) begin
				s2_valid_q <= 1'b0;
			end
			if (cfg.load) begin
				pc_q <= ADDRESS_BITS'(cfg.start);
			end else if (exec_go) begin
				pc_q <= pc_n;
			end
			if (exec_go) begin
				if (wr) gpr_valid_q[op_s2.x] <= 1'b1;
				if (wr && op_s2.x == c8ie_pkg::V0_IDX) v0_q <= res;
				vf_q  <= vf_n;
				idx_q <= idx_n;
				dt_q  <= dt_n;
				st_q  <= st_n;
				sp_q  <= sp_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			next_pc_q       <= pc_n[c8ie_pkg::PC_OUT_W-1:0];
			index_value_q   <= idx_n;
			dest_index_q    <= wr ? op_s2.x : 4'h0;
			dest_value_q    <= !wr ? 8'h00 : (op_s2.x == c8ie_pkg::VF_IDX) ? vf_n : res;
			dest_written_q  <= wr;
			flag_register_q <= vf_n;
			stack_level_q   <= c8ie_pkg::LEVEL_OUT_W'(sp_n);
			fault_q         <= fault_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= exec_go || (out_valid_q && !result.ready);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.next_pc       = next_pc_q;
	assign result.index_value   = index_value_q;
	assign result.dest_index    = dest_index_q;
	assign result.dest_value    = dest_value_q;
	assign result.dest_written  = dest_written_q;
	assign result.flag_register = flag_register_q;
	assign result.stack_level   = stack_level_q;
	assign result.fault         = fault_q;

	a_exec_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> out_valid_q)
		else $error("executed op did not reach the result register");

	a_pop_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> s2_valid_q)
		else $error("popped op lost before execute");

	a_overflow_holds_sp: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && fault_n == c8ie_pkg::FAULT_OVERFLOW) |=> sp_q == $past(sp_q))
		else $error("stack pointer moved on overflow");

	a_sp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_no_dest_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !dest_written_q) |-> (dest_index_q == 4'h0 && dest_value_q == 8'h00))
		else $error("destination fields set without a register write");

endmodule

@@ sv/chip8_instruction_execute.sv @@
// top level of the chip8 instruction execute block: apb register, front, queue, back
// depends on c8ie_pkg, c8ie_ifs, c8ie_front, c8ie_fifo and c8ie_back
//
// Executes one CHIP-8 instruction per beat on the instr channel and returns one
// result beat per instruction on the result channel, in order. Sustained rate is one
// instruction per cycle while the result channel is ready. The decoded op is written
// into a two-entry queue at the accepting edge. It is then popped into the register
// file read stage, and the combinational execute writes the result register. The
// execute stage is what sets the rate, since it updates pc, index, registers, stack
// and timers in the cycle it fires. While a result waits, one more instruction can
// sit in the read stage and the queue keeps taking beats until it holds two. The apb
// register at byte address 0 holds start_address. Writing it also loads the program
// counter, so write it only while no instruction is in flight.
module chip8_instruction_execute #(
	parameter int STACK_DEPTH  = c8ie_pkg::STACK_DEPTH_DEF,
	parameter int ADDRESS_BITS = c8ie_pkg::ADDRESS_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [c8ie_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [c8ie_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [c8ie_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	c8ie_in_if.sink                             instr,
	c8ie_out_if.source                          result
);

	logic [11:0]    start_q;
	logic           reg_wr;
	c8ie_pkg::cfg_t cfg;
	logic           push;
	logic           push_ready;
	c8ie_pkg::op_t  push_op;
	logic           head_valid;
	c8ie_pkg::op_t  head_op;
	logic           pop;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == c8ie_pkg::REG_START_ADDRESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= c8ie_pkg::START_RESET;
		end else if (reg_wr) begin
			start_q <= pwdata[11:0];
		end
	end

	assign prdata = (paddr[2] == c8ie_pkg::REG_START_ADDRESS)
		? c8ie_pkg::APB_DATA_W'(start_q) : '0;

	assign cfg.load  = reg_wr;
	assign cfg.start = pwdata[11:0];

	c8ie_front u_front (
		.instr      (instr),
		.push       (push),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	c8ie_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop)
	);

	c8ie_back #(
		.STACK_DEPTH  (STACK_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.result     (result)
	);

endmodule
